@@ rtl/dss_pkg.sv @@
// Shared types and constants of the deadline slot scheduler.
`default_nettype none
package dss_pkg;

    localparam int SLOTS   = 64;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int GRP_W   = 3;
    localparam int GRP_N   = 1 << GRP_W;
    localparam int DL_W    = 7;
    localparam int ID_W    = 8;
    localparam int PROF_W  = 16;
    localparam int KIND_W  = 2;

    // Input operation codes
    localparam logic OP_PLACE  = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_PLACE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ENTRY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PLACE_SRCH,
        ST_PLACE_ANS,
        ST_FIN_SRCH,
        ST_FIN_EMPTY,
        ST_WALK,
        ST_EMIT
    } dss_state_t;

    // Request to the shared downward search unit
    typedef struct packed {
        logic              start;
        logic [SLOT_W-1:0] from_idx;
        logic              want_set;
    } dss_srch_req_t;

    // Answer of the search unit
    typedef struct packed {
        logic              done;
        logic              found;
        logic [SLOT_W-1:0] idx;
    } dss_srch_rsp_t;

endpackage
`default_nettype wire

@@ rtl/dss_search.sv @@
// Downward search over the occupancy map, one group of slots per cycle.
`default_nettype none
module dss_search (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [dss_pkg::SLOTS-1:0]    occ,
    input  wire dss_pkg::dss_srch_req_t       req,
    output dss_pkg::dss_srch_rsp_t            rsp
);
    import dss_pkg::*;

    logic              busy_reg, busy_next;
    logic [SLOT_W-1:0] cur_reg, cur_next;
    logic              want_reg, want_next;

    logic [GRP_N-1:0]        grp_bits;
    logic [GRP_N-1:0]        cand;
    logic [GRP_W-1:0]        pe;
    logic                    hit;
    logic [SLOT_W-GRP_W-1:0] grp;

    // Masked priority encode of the current group
    always_comb
    begin
        grp      = cur_reg[SLOT_W-1:GRP_W];
        grp_bits = occ[{grp, {GRP_W{1'b0}}} +: GRP_N];
        pe       = '0;
        hit      = 1'b0;
        for (int b = 0; b < GRP_N; b++)
        begin
            cand[b] = (grp_bits[b] == want_reg) && (GRP_W'(b) <= cur_reg[GRP_W-1:0]);
            if (cand[b])
            begin
                pe  = GRP_W'(b);
                hit = 1'b1;
            end
        end
    end

    assign rsp.done  = busy_reg && (hit || (grp == '0));
    assign rsp.found = hit;
    assign rsp.idx   = {grp, pe};

    // Step to the next lower group, or load a new search
    always_comb
    begin
        busy_next = busy_reg;
        cur_next  = cur_reg;
        want_next = want_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cur_next  = req.from_idx;
            want_next = req.want_set;
        end
        else if (rsp.done)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg)
        begin
            cur_next = {grp - 1'b1, {GRP_W{1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cur_reg  <= '0;
            want_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cur_reg  <= cur_next;
            want_reg <= want_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/dss_store.sv @@
// Per-slot profit and job id memory, one write and one registered read port.
`default_nettype none
module dss_store (
    input  wire logic                         clk,
    input  wire logic                         wr_en,
    input  wire logic [dss_pkg::SLOT_W-1:0]   wr_addr,
    input  wire logic [dss_pkg::PROF_W-1:0]   wr_profit,
    input  wire logic [dss_pkg::ID_W-1:0]     wr_id,
    input  wire logic                         rd_en,
    input  wire logic [dss_pkg::SLOT_W-1:0]   rd_addr,
    output logic [dss_pkg::PROF_W-1:0]        rd_profit,
    output logic [dss_pkg::ID_W-1:0]          rd_id
);
    import dss_pkg::*;

    logic [PROF_W-1:0] profit_mem [SLOTS];
    logic [ID_W-1:0]   id_mem     [SLOTS];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            profit_mem[wr_addr] <= wr_profit;
            id_mem[wr_addr]     <= wr_id;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_profit <= profit_mem[rd_addr];
            rd_id     <= id_mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ rtl/deadline_slot_scheduler_core.sv @@
// Top level of the deadline slot scheduler: sequencer, occupancy map, output register.
//
// Usage: jobs arrive on the input channel (in_valid/in_ready) already sorted by
// descending profit. A place item (operation 0) puts the job into the latest free
// slot at or before its deadline and returns one answer (kind 0) with accepted,
// slot, profit and job id. A finish item (operation 1) returns every filled slot in
// ascending order (kind 1), last set on the final one, and clears the map; with no
// slot filled it returns a single empty marker (kind 2).
// Timing: one item at a time; in_ready is high only when the sequencer is idle.
// A placement runs a downward search in the shared search unit, which scans eight
// slots per cycle, then loads the answer; a zero deadline skips the search and goes
// straight to loading the answer. in_ready returns in the cycle after the final
// result is loaded. A finish uses the search unit to locate the highest filled slot,
// then walks upwards from slot 0 to it, reading each filled slot from memory and
// skipping each empty one.
// Results sit in an output register; a stalled receiver (out_ready low) holds the
// sequencer at the next result, and a new item may be taken while one result waits.
// Reset clears the occupancy map and all control state; the slot memory is not
// cleared, since a slot is always written in the same cycle as its occupancy bit is set.
`default_nettype none
module deadline_slot_scheduler_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         operation,
    input  wire logic [dss_pkg::ID_W-1:0]     job_id,
    input  wire logic [dss_pkg::DL_W-1:0]     deadline,
    input  wire logic [dss_pkg::PROF_W-1:0]   profit,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [dss_pkg::KIND_W-1:0]        kind,
    output logic                              accepted,
    output logic [dss_pkg::SLOT_W-1:0]        slot_index,
    output logic [dss_pkg::PROF_W-1:0]        slot_profit,
    output logic [dss_pkg::ID_W-1:0]          slot_job_id,
    output logic                              last
);
    import dss_pkg::*;

    dss_state_t        state_reg, state_next;
    logic [SLOTS-1:0]  occ_reg, occ_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [PROF_W-1:0] prof_reg, prof_next;
    logic              found_reg, found_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [SLOT_W-1:0] lslot_reg, lslot_next;

    logic              out_valid_reg, out_valid_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic              acc_reg, acc_next;
    logic [SLOT_W-1:0] oslot_reg, oslot_next;
    logic [PROF_W-1:0] oprof_reg, oprof_next;
    logic [ID_W-1:0]   oid_reg, oid_next;
    logic              olast_reg, olast_next;

    logic              in_fire;
    logic              out_free;
    logic              dl_zero;
    logic [DL_W-1:0]   dl_sat;
    logic              is_last;

    dss_srch_req_t     srch_req;
    dss_srch_rsp_t     srch_rsp;

    logic              wr_en;
    logic              rd_en;
    logic [PROF_W-1:0] rd_profit;
    logic [ID_W-1:0]   rd_id;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign dl_zero  = (deadline == '0);
    assign dl_sat   = (deadline > DL_W'(SLOTS)) ? DL_W'(SLOTS) : deadline;
    assign is_last  = (slot_reg == lslot_reg);

    // Shared search unit and slot memory
    dss_search u_search (
        .clk   (clk),
        .rst_n (rst_n),
        .occ   (occ_reg),
        .req   (srch_req),
        .rsp   (srch_rsp)
    );

    dss_store u_store (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (srch_rsp.idx),
        .wr_profit (prof_reg),
        .wr_id     (id_reg),
        .rd_en     (rd_en),
        .rd_addr   (slot_reg),
        .rd_profit (rd_profit),
        .rd_id     (rd_id)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (operation == OP_FINISH)
                        state_next = ST_FIN_SRCH;
                    else if (dl_zero)
                        state_next = ST_PLACE_ANS;
                    else
                        state_next = ST_PLACE_SRCH;
                end
            end
            ST_PLACE_SRCH:
            begin
                if (srch_rsp.done)
                    state_next = ST_PLACE_ANS;
            end
            ST_PLACE_ANS:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            ST_FIN_SRCH:
            begin
                if (srch_rsp.done)
                    state_next = srch_rsp.found ? ST_WALK : ST_FIN_EMPTY;
            end
            ST_FIN_EMPTY:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            ST_WALK:
            begin
                if (occ_reg[slot_reg])
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                    state_next = is_last ? ST_IDLE : ST_WALK;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath control and output register loading
    always_comb
    begin
        occ_next       = occ_reg;
        id_next        = id_reg;
        prof_next      = prof_reg;
        found_next     = found_reg;
        slot_next      = slot_reg;
        lslot_next     = lslot_reg;
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        acc_next       = acc_reg;
        oslot_next     = oslot_reg;
        oprof_next     = oprof_reg;
        oid_next       = oid_reg;
        olast_next     = olast_reg;
        srch_req       = '0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    id_next    = job_id;
                    prof_next  = profit;
                    found_next = 1'b0;
                    if (operation == OP_FINISH)
                    begin
                        srch_req.start    = 1'b1;
                        srch_req.from_idx = SLOT_W'(SLOTS - 1);
                        srch_req.want_set = 1'b1;
                    end
                    else if (!dl_zero)
                    begin
                        srch_req.start    = 1'b1;
                        srch_req.from_idx = SLOT_W'(dl_sat - 1'b1);
                        srch_req.want_set = 1'b0;
                    end
                end
            end
            ST_PLACE_SRCH:
            begin
                if (srch_rsp.done)
                begin
                    found_next = srch_rsp.found;
                    slot_next  = srch_rsp.idx;
                    if (srch_rsp.found)
                    begin
                        wr_en                  = 1'b1;
                        occ_next[srch_rsp.idx] = 1'b1;
                    end
                end
            end
            ST_PLACE_ANS:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_PLACE;
                    acc_next       = found_reg;
                    oslot_next     = found_reg ? slot_reg : '0;
                    oprof_next     = found_reg ? prof_reg : '0;
                    oid_next       = found_reg ? id_reg : '0;
                    olast_next     = 1'b1;
                end
            end
            ST_FIN_SRCH:
            begin
                if (srch_rsp.done)
                begin
                    lslot_next = srch_rsp.idx;
                    slot_next  = '0;
                end
            end
            ST_FIN_EMPTY:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_EMPTY;
                    acc_next       = 1'b0;
                    oslot_next     = '0;
                    oprof_next     = '0;
                    oid_next       = '0;
                    olast_next     = 1'b1;
                    occ_next       = '0;
                end
            end
            ST_WALK:
            begin
                // Read a filled slot, skip an empty one
                if (occ_reg[slot_reg])
                    rd_en = 1'b1;
                else
                    slot_next = slot_reg + 1'b1;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_ENTRY;
                    acc_next       = 1'b0;
                    oslot_next     = slot_reg;
                    oprof_next     = rd_profit;
                    oid_next       = rd_id;
                    olast_next     = is_last;
                    if (is_last)
                        occ_next = '0;
                    else
                        slot_next = slot_reg + 1'b1;
                end
            end
            default:
            begin
                srch_req = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        id_reg    <= id_next;
        prof_reg  <= prof_next;
        found_reg <= found_next;
        slot_reg  <= slot_next;
        lslot_reg <= lslot_next;
        kind_reg  <= kind_next;
        acc_reg   <= acc_next;
        oslot_reg <= oslot_next;
        oprof_reg <= oprof_next;
        oid_reg   <= oid_next;
        olast_reg <= olast_next;
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign accepted    = acc_reg;
    assign slot_index  = oslot_reg;
    assign slot_profit = oprof_reg;
    assign slot_job_id = oid_reg;
    assign last        = olast_reg;

endmodule
`default_nettype wire
